### src/lkd_pkg.sv
// Package: shared types, codes and segment table for the LED frame sender
`timescale 1ns / 1ps
package lkd_pkg;

    typedef enum logic [1:0] {
        FUNC_OFF    = 2'd0,
        FUNC_ON     = 2'd1,
        FUNC_SINGLE = 2'd2,
        FUNC_FOUR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_LOAD  = 2'd1,
        ST_SHIFT = 2'd2,
        ST_OUT   = 2'd3
    } state_t;

    localparam logic [7:0] CMD_OFF   = 8'h80;
    localparam logic [7:0] CMD_ON    = 8'h88;
    localparam logic [7:0] CMD_WRITE = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] BYTE_NULL = 8'h00;

    localparam logic [3:0] MAX_POSITION = 4'd7;
    localparam logic [3:0] MAX_DIGIT    = 4'd9;
    localparam logic [3:0] LAST_STEP    = 4'd10;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] position;
        logic [3:0] digit0;
        logic [3:0] digit1;
        logic [3:0] digit2;
        logic [3:0] digit3;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } word_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] v);
        logic [7:0] p;
        case (v)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = BYTE_NULL;
        endcase
        return p;
    endfunction

endpackage

### src/lkd_if.sv
// Interfaces: request channel and byte word channel
`timescale 1ns / 1ps
interface lkd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] position;
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;

    modport source (output valid, func, position, digit0, digit1, digit2, digit3,
                    input ready);
    modport sink   (input valid, func, position, digit0, digit1, digit2, digit3,
                    output ready);
endinterface

interface lkd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;

    modport source (output valid, tx_byte, frame_start, frame_end, last,
                    input ready);
    modport sink   (input valid, tx_byte, frame_start, frame_end, last,
                    output ready);
endinterface

### src/lkd_byte_gen.sv
// Byte generator: word content for one step of a request
`timescale 1ns / 1ps
module lkd_byte_gen
    import lkd_pkg::*;
(
    input  req_t       req,
    input  logic [3:0] step,
    output word_t      word
);

    logic [1:0] digit_idx;
    logic [3:0] digit_val;

    always_comb
    begin
        digit_idx = 2'(step[3:1] - 3'd1);
        case (digit_idx)
            2'd0:    digit_val = req.digit0;
            2'd1:    digit_val = req.digit1;
            2'd2:    digit_val = req.digit2;
            default: digit_val = req.digit3;
        endcase

        word = '0;
        case (func_t'(req.func))
            FUNC_OFF:
            begin
                word = '{tx_byte: CMD_OFF, frame_start: 1'b1, frame_end: 1'b1, last: 1'b1};
            end
            FUNC_ON:
            begin
                word = '{tx_byte: CMD_ON, frame_start: 1'b1, frame_end: 1'b1, last: 1'b1};
            end
            FUNC_SINGLE:
            begin
                if (step == 4'd0)
                begin
                    word.tx_byte     = CMD_ADDR + {3'd0, req.position, 1'b0};
                    word.frame_start = 1'b1;
                end
                else
                begin
                    word.tx_byte   = seg_pattern(req.digit0);
                    word.frame_end = 1'b1;
                    word.last      = 1'b1;
                end
            end
            default:
            begin
                if (step == 4'd0)
                begin
                    word = '{tx_byte: CMD_WRITE, frame_start: 1'b1, frame_end: 1'b1,
                             last: 1'b0};
                end
                else if (step == 4'd1)
                begin
                    word.tx_byte     = CMD_ADDR;
                    word.frame_start = 1'b1;
                end
                else if (step == LAST_STEP)
                begin
                    word = '{tx_byte: CMD_ON, frame_start: 1'b1, frame_end: 1'b1, last: 1'b1};
                end
                else if (!step[0])
                begin
                    word.tx_byte = seg_pattern(digit_val);
                end
                else
                begin
                    word.tx_byte   = BYTE_NULL;
                    word.frame_end = (step == 4'd9);
                end
            end
        endcase
    end

endmodule

### src/lkd_shifter.sv
// Bit shifter: sends a byte LSB first, each bit in a drive phase then a sample phase, with readback
`timescale 1ns / 1ps
module lkd_shifter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] load_byte,
    output logic       done,
    output logic [7:0] sent_byte
);

    logic       busy_reg,  busy_next;
    logic       done_reg,  done_next;
    logic [3:0] phase_reg, phase_next;
    logic [7:0] tx_reg,    tx_next;
    logic [7:0] rx_reg,    rx_next;
    logic       data_reg,  data_next;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        data_next  = data_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 4'd0;
            tx_next    = load_byte;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 4'd1;
            if (!phase_reg[0])
            begin
                data_next = tx_reg[0];
            end
            else
            begin
                rx_next = {data_reg, rx_reg[7:1]};
                tx_next = {1'b0, tx_reg[7:1]};
            end
            if (phase_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 4'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg   <= tx_next;
        rx_reg   <= rx_next;
        data_reg <= data_next;
    end

    assign done      = done_reg;
    assign sent_byte = rx_reg;

endmodule

### src/led_key_display_frame_sender_top.sv
// Top level: LED controller frame sender, sequencer around a shared bit shifter
//
//  channel | dir | handshake     | word
//  req     | in  | valid/ready   | func, position, digit0..digit3
//  rsp     | out | valid/ready   | tx_byte, frame_start, frame_end, last
//
// Each byte goes through the load, shift and out states, and the out state holds
// until rsp.ready; a four-digit request sends 11 bytes. The bit shifter sends the 8
// bits of each byte, and its readback is the byte that rsp carries.
// One request at a time; req.ready is high only when idle.
// Rejected requests are taken while idle and emit nothing.
// Reset is asynchronous, active low, and returns to idle.
`timescale 1ns / 1ps
module led_key_display_frame_sender_top
    import lkd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    lkd_req_if.sink          req,
    lkd_out_if.source        rsp
);

    state_t     state_reg, state_next;
    logic [3:0] step_reg,  step_next;
    req_t       req_reg,   req_next;
    word_t      out_reg,   out_next;
    word_t      info_reg,  info_next;
    word_t      gen_word;
    req_t       req_in;
    logic       shift_start;
    logic       shift_done;
    logic [7:0] sent_byte;
    logic       reject;

    assign req_in = '{func: req.func, position: req.position, digit0: req.digit0,
                      digit1: req.digit1, digit2: req.digit2, digit3: req.digit3};

    lkd_byte_gen u_byte_gen
    (
        .req  (req_reg),
        .step (step_reg),
        .word (gen_word)
    );

    lkd_shifter u_shifter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (shift_start),
        .load_byte (gen_word.tx_byte),
        .done      (shift_done),
        .sent_byte (sent_byte)
    );

    always_comb
    begin
        reject = (func_t'(req.func) == FUNC_SINGLE) &&
                 ((req.position > MAX_POSITION) || (req.digit0 > MAX_DIGIT));
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        req_next    = req_reg;
        out_next    = out_reg;
        info_next   = info_reg;
        shift_start = 1'b0;
        req.ready   = 1'b0;
        rsp.valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    req_next  = req_in;
                    step_next = 4'd0;
                    if (!reject)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                shift_start = 1'b1;
                info_next   = gen_word;
                state_next  = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (shift_done)
                begin
                    out_next         = info_reg;
                    out_next.tx_byte = sent_byte;
                    state_next       = ST_OUT;
                end
            end
            ST_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    if (out_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next  = step_reg + 4'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        out_reg  <= out_next;
        info_reg <= info_next;
    end

    assign rsp.tx_byte     = out_reg.tx_byte;
    assign rsp.frame_start = out_reg.frame_start;
    assign rsp.frame_end   = out_reg.frame_end;
    assign rsp.last        = out_reg.last;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request taken while a word is pending");

    a_done_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        shift_done |-> (state_reg == ST_SHIFT))
        else $error("shifter finished outside the shift state");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && rsp.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last word");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (step_reg <= LAST_STEP))
        else $error("step counter beyond the last step");

endmodule
